// ===== src/pidt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pidt_pkg;

    localparam int DATA_W  = 32;
    localparam int ACC_W   = 48;
    localparam int MUL_A_W = 53;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 64;
    localparam int TERM_W  = 61;

    localparam logic [1:0] ST_COMPUTED = 2'd0;
    localparam logic [1:0] ST_FIRST    = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;

    localparam logic [2:0] REG_GAIN_P     = 3'd0;
    localparam logic [2:0] REG_GAIN_I     = 3'd1;
    localparam logic [2:0] REG_GAIN_D     = 3'd2;
    localparam logic [2:0] REG_LIMIT_LOW  = 3'd3;
    localparam logic [2:0] REG_LIMIT_HIGH = 3'd4;

    typedef logic [TERM_W-1:0] t_term;

endpackage
`default_nettype wire

// ===== src/pidt_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pidt_mul #(
    parameter int A_W = pidt_pkg::MUL_A_W,
    parameter int B_W = pidt_pkg::MUL_B_W
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [A_W-1:0]     i_a,
    input  wire logic [B_W-1:0]     i_b,
    output logic                    o_done,
    output logic [A_W+B_W-1:0]      o_prod
);
    localparam int C_W = $clog2(B_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [C_W-1:0]   r_cnt;
    logic [A_W-1:0]   r_a;
    logic [B_W-1:0]   r_b;
    logic [A_W+B_W-1:0] r_p;
    logic [A_W+B_W-1:0] addend;

    // one multiplier bit per cycle, most significant first
    assign addend = r_b[B_W-1] ? {{B_W{1'b0}}, r_a} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= C_W'(B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - C_W'(1);
                if (r_cnt == C_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            r_p <= {r_p[A_W+B_W-2:0], 1'b0} + addend;
            r_b <= {r_b[B_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule
`default_nettype wire

// ===== src/pidt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pidt_div #(
    parameter int N_W = pidt_pkg::DIV_N_W,
    parameter int D_W = pidt_pkg::DATA_W
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_num,
    input  wire logic [D_W-1:0] i_den,
    output logic                o_done,
    output logic [N_W-1:0]      o_quot
);
    localparam int C_W = $clog2(N_W + 1);

    logic           r_busy;
    logic           r_done;
    logic [C_W-1:0] r_cnt;
    logic [N_W-1:0] r_q;
    logic [D_W-1:0] r_rem;
    logic [D_W-1:0] r_den;
    logic [D_W:0]   trial;
    logic [D_W:0]   diff;
    logic           ge;

    // restoring division, one quotient bit per cycle
    assign trial = {r_rem, r_q[N_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= C_W'(N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - C_W'(1);
                if (r_cnt == C_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
            r_q   <= {r_q[N_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

// ===== src/pid_timestamped_antiwindup_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// PID controller with time-stamped samples and integral clamp.
// Input channel: i_in_valid / o_in_stall carries target, measured, time_ms and
// restart; one transaction per sample. Output channel: o_out_valid / i_out_stall
// carries drive and status; exactly one result transaction per sample.
// Configuration: write i_cfg_data to register i_cfg_index (gain_p, gain_i,
// gain_d, limit_low, limit_high) with i_cfg_we, only while the block is idle.
// Sequence, with the output register free: a first sample or a zero interval
// moves the sequencer to S_EMIT, which loads the output register. A computed
// sample runs S_IMUL, S_IDIV, then S_LDIV and S_HDIV when gain_i is nonzero (two
// extra divisions for the integral bounds), then S_DMUL, S_DDIV, S_PMUL, S_AMUL,
// S_GMUL and S_EMIT; the next sample is taken once the sequencer is back in
// S_IDLE. The steps use the shared bit-serial multiplier and the bit-serial
// divider, which the sequencer runs in turn.
// One sample is processed at a time; o_in_stall is high while it is at work.
// A finished result sits in the output register while the next sample is
// accepted; if the receiver stalls, the result holds and the next result waits
// in the sequencer until the output register frees up.
// Reset (synchronous, active low) clears the integral, previous error and
// stored time, and loads the register defaults (gains zero, full limits).
module pid_timestamped_antiwindup_core #(
    parameter int unsigned TICKS_PER_SECOND = 1000
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_target,
    input  wire logic [31:0] i_measured,
    input  wire logic [31:0] i_time_ms,
    input  wire logic        i_restart,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_drive,
    output logic [1:0]       o_status,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    localparam int A_W  = pidt_pkg::MUL_A_W;
    localparam int B_W  = pidt_pkg::MUL_B_W;
    localparam int P_W  = pidt_pkg::PROD_W;
    localparam int N_W  = pidt_pkg::DIV_N_W;
    localparam int AC_W = pidt_pkg::ACC_W;
    localparam int T_W  = pidt_pkg::TERM_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_IMUL = 4'd1;
    localparam logic [3:0] S_IDIV = 4'd2;
    localparam logic [3:0] S_LDIV = 4'd3;
    localparam logic [3:0] S_HDIV = 4'd4;
    localparam logic [3:0] S_DMUL = 4'd5;
    localparam logic [3:0] S_DDIV = 4'd6;
    localparam logic [3:0] S_PMUL = 4'd7;
    localparam logic [3:0] S_AMUL = 4'd8;
    localparam logic [3:0] S_GMUL = 4'd9;
    localparam logic [3:0] S_EMIT = 4'd10;

    localparam logic [63:0] INC_CAP  = 64'h0001_0000_0000_0000;
    localparam logic signed [49:0] ACC_MAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] ACC_MIN = -50'sh0_8000_0000_0000;
    localparam logic [T_W-1:0] TERM_CAP = T_W'(1) << 60;

    // configuration registers
    logic [31:0] r_gain_p, r_gain_i, r_gain_d, r_limit_low, r_limit_high;

    // control
    logic [3:0]  r_state, n_state;
    logic        r_mul_start, n_mul_start;
    logic        r_div_start, n_div_start;
    logic        r_out_valid, n_out_valid;

    // state of the controller
    logic [AC_W-1:0] r_acc, n_acc;
    logic [31:0]     r_prev_err, n_prev_err;
    logic [31:0]     r_prev_time, n_prev_time;

    // working payload
    logic [A_W-1:0]  r_opa, n_opa;
    logic [B_W-1:0]  r_opb, n_opb;
    logic [N_W-1:0]  r_num, n_num;
    logic [31:0]     r_den, n_den;
    logic [31:0]     r_err, n_err;
    logic [31:0]     r_ticks, n_ticks;
    logic [31:0]     r_now, n_now;
    logic [48:0]     r_ilo, n_ilo;
    logic [A_W-1:0]  r_dmag, n_dmag;
    logic            r_dneg, n_dneg;
    logic [63:0]     r_sum, n_sum;
    logic [31:0]     r_res_drive, n_res_drive;
    logic [1:0]      r_res_status, n_res_status;
    logic [31:0]     r_drive, n_drive;
    logic [1:0]      r_status, n_status;

    // arithmetic units
    logic            mul_done, div_done;
    logic [P_W-1:0]  mul_prod;
    logic [N_W-1:0]  div_quot;

    pidt_mul #(.A_W(A_W), .B_W(B_W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_opa),
        .i_b     (r_opb),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    pidt_div #(.N_W(N_W), .D_W(32)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    logic in_acc, out_free;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // error of the incoming sample, saturated to 32 bits
    logic signed [32:0] raw_err;
    logic [31:0]        in_err, in_err_mag, eff_prev;
    assign raw_err = $signed({i_target[31], i_target}) - $signed({i_measured[31], i_measured});
    always_comb begin
        if (raw_err > 33'sd2147483647) begin
            in_err = 32'h7FFF_FFFF;
        end else if (raw_err < -33'sd2147483648) begin
            in_err = 32'h8000_0000;
        end else begin
            in_err = raw_err[31:0];
        end
    end
    assign in_err_mag = in_err[31] ? (~in_err + 32'd1) : in_err;
    assign eff_prev   = i_restart ? 32'd0 : r_prev_time;

    // magnitudes of held values
    logic [31:0]      err_mag, lo_mag, hi_mag;
    logic [AC_W-1:0]  acc_mag;
    logic signed [32:0] diff;
    logic [32:0]      diff_mag;
    assign err_mag  = r_err[31] ? (~r_err + 32'd1) : r_err;
    assign acc_mag  = r_acc[AC_W-1] ? (~r_acc + AC_W'(1)) : r_acc;
    assign lo_mag   = r_limit_low[31] ? (~r_limit_low + 32'd1) : r_limit_low;
    assign hi_mag   = r_limit_high[31] ? (~r_limit_high + 32'd1) : r_limit_high;
    assign diff     = $signed({r_err[31], r_err}) - $signed({r_prev_err[31], r_prev_err});
    assign diff_mag = diff[32] ? (~diff + 33'd1) : diff;

    // integral increment and saturated accumulate
    logic [48:0]        inc_mag;
    logic signed [49:0] inc_s, acc_sum;
    logic [AC_W-1:0]    acc_sat;
    assign inc_mag = (div_quot > INC_CAP) ? 49'(INC_CAP) : div_quot[48:0];
    assign inc_s   = r_err[31] ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
    assign acc_sum = $signed({{2{r_acc[AC_W-1]}}, r_acc}) + inc_s;
    always_comb begin
        if (acc_sum > ACC_MAX) begin
            acc_sat = ACC_MAX[AC_W-1:0];
        end else if (acc_sum < ACC_MIN) begin
            acc_sat = ACC_MIN[AC_W-1:0];
        end else begin
            acc_sat = acc_sum[AC_W-1:0];
        end
    end

    // integral bounds
    logic [48:0]        q49, ihi;
    logic signed [48:0] acc_ext;
    logic [AC_W-1:0]    acc_clamped;
    assign q49     = div_quot[48:0];
    assign ihi     = r_limit_high[31] ? (~q49 + 49'd1) : q49;
    assign acc_ext = $signed({r_acc[AC_W-1], r_acc});
    always_comb begin
        if (acc_ext < $signed(r_ilo)) begin
            acc_clamped = r_ilo[AC_W-1:0];
        end else if (acc_ext > $signed(ihi)) begin
            acc_clamped = ihi[AC_W-1:0];
        end else begin
            acc_clamped = r_acc;
        end
    end

    // gain term: product >> 16, capped at 2^60, signed by the operand
    logic [P_W-17:0]    prod_sh;
    pidt_pkg::t_term    term_mag;
    logic               term_neg;
    logic signed [63:0] term_s, sum_next;
    logic [31:0]        drive_clamped;
    assign prod_sh  = mul_prod[P_W-1:16];
    assign term_mag = (prod_sh > (P_W-16)'(TERM_CAP)) ? TERM_CAP : prod_sh[T_W-1:0];
    always_comb begin
        unique case (r_state)
            S_PMUL:  term_neg = r_err[31];
            S_AMUL:  term_neg = r_acc[AC_W-1];
            default: term_neg = r_dneg;
        endcase
    end
    assign term_s   = term_neg ? -$signed({3'b0, term_mag}) : $signed({3'b0, term_mag});
    assign sum_next = $signed(r_sum) + term_s;
    always_comb begin
        if (sum_next < $signed({{32{r_limit_low[31]}}, r_limit_low})) begin
            drive_clamped = r_limit_low;
        end else if (sum_next > $signed({{32{r_limit_high[31]}}, r_limit_high})) begin
            drive_clamped = r_limit_high;
        end else begin
            drive_clamped = sum_next[31:0];
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_mul_start  = 1'b0;
        n_div_start  = 1'b0;
        n_out_valid  = r_out_valid;
        n_acc        = r_acc;
        n_prev_err   = r_prev_err;
        n_prev_time  = r_prev_time;
        n_opa        = r_opa;
        n_opb        = r_opb;
        n_num        = r_num;
        n_den        = r_den;
        n_err        = r_err;
        n_ticks      = r_ticks;
        n_now        = r_now;
        n_ilo        = r_ilo;
        n_dmag       = r_dmag;
        n_dneg       = r_dneg;
        n_sum        = r_sum;
        n_res_drive  = r_res_drive;
        n_res_status = r_res_status;
        n_drive      = r_drive;
        n_status     = r_status;

        // drop the output once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_restart) begin
                        n_acc      = '0;
                        n_prev_err = '0;
                    end
                    if (eff_prev == 32'd0) begin
                        // first sample: store the time only
                        n_prev_time  = i_time_ms;
                        n_res_drive  = '0;
                        n_res_status = pidt_pkg::ST_FIRST;
                        n_state      = S_EMIT;
                    end else if (i_time_ms == eff_prev) begin
                        n_res_drive  = '0;
                        n_res_status = pidt_pkg::ST_ZERO;
                        n_state      = S_EMIT;
                    end else begin
                        n_err       = in_err;
                        n_ticks     = i_time_ms - eff_prev;
                        n_now       = i_time_ms;
                        n_opa       = A_W'(in_err_mag);
                        n_opb       = i_time_ms - eff_prev;
                        n_mul_start = 1'b1;
                        n_state     = S_IMUL;
                    end
                end
            end
            S_IMUL: begin
                if (mul_done) begin
                    n_num       = mul_prod[N_W-1:0];
                    n_den       = 32'(TICKS_PER_SECOND);
                    n_div_start = 1'b1;
                    n_state     = S_IDIV;
                end
            end
            S_IDIV: begin
                if (div_done) begin
                    n_acc = acc_sat;
                    if (r_gain_i != 32'd0) begin
                        n_num       = {16'd0, lo_mag, 16'd0};
                        n_den       = r_gain_i;
                        n_div_start = 1'b1;
                        n_state     = S_LDIV;
                    end else begin
                        n_opa       = A_W'(diff_mag);
                        n_opb       = 32'(TICKS_PER_SECOND);
                        n_mul_start = 1'b1;
                        n_state     = S_DMUL;
                    end
                end
            end
            S_LDIV: begin
                if (div_done) begin
                    n_ilo       = r_limit_low[31] ? (~q49 + 49'd1) : q49;
                    n_num       = {16'd0, hi_mag, 16'd0};
                    n_den       = r_gain_i;
                    n_div_start = 1'b1;
                    n_state     = S_HDIV;
                end
            end
            S_HDIV: begin
                if (div_done) begin
                    // when the limits cross, the lower bound wins only below it; all else takes the upper
                    n_acc       = acc_clamped;
                    n_opa       = A_W'(diff_mag);
                    n_opb       = 32'(TICKS_PER_SECOND);
                    n_mul_start = 1'b1;
                    n_state     = S_DMUL;
                end
            end
            S_DMUL: begin
                if (mul_done) begin
                    n_num       = mul_prod[N_W-1:0];
                    n_den       = r_ticks;
                    n_div_start = 1'b1;
                    n_state     = S_DDIV;
                end
            end
            S_DDIV: begin
                if (div_done) begin
                    n_dmag      = div_quot[A_W-1:0];
                    n_dneg      = diff[32];
                    n_sum       = '0;
                    n_opa       = A_W'(err_mag);
                    n_opb       = r_gain_p;
                    n_mul_start = 1'b1;
                    n_state     = S_PMUL;
                end
            end
            S_PMUL: begin
                if (mul_done) begin
                    n_sum       = sum_next;
                    n_opa       = A_W'(acc_mag);
                    n_opb       = r_gain_i;
                    n_mul_start = 1'b1;
                    n_state     = S_AMUL;
                end
            end
            S_AMUL: begin
                if (mul_done) begin
                    n_sum       = sum_next;
                    n_opa       = r_dmag;
                    n_opb       = r_gain_d;
                    n_mul_start = 1'b1;
                    n_state     = S_GMUL;
                end
            end
            S_GMUL: begin
                if (mul_done) begin
                    n_res_drive  = drive_clamped;
                    n_res_status = pidt_pkg::ST_COMPUTED;
                    n_prev_err   = r_err;
                    n_prev_time  = r_now;
                    n_state      = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_drive     = r_res_drive;
                    n_status    = r_res_status;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mul_start  <= 1'b0;
            r_div_start  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_acc        <= '0;
            r_prev_err   <= '0;
            r_prev_time  <= '0;
            r_gain_p     <= '0;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_limit_low  <= 32'h8000_0000;
            r_limit_high <= 32'h7FFF_FFFF;
        end else begin
            r_state     <= n_state;
            r_mul_start <= n_mul_start;
            r_div_start <= n_div_start;
            r_out_valid <= n_out_valid;
            r_acc       <= n_acc;
            r_prev_err  <= n_prev_err;
            r_prev_time <= n_prev_time;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pidt_pkg::REG_GAIN_P:     r_gain_p     <= i_cfg_data;
                    pidt_pkg::REG_GAIN_I:     r_gain_i     <= i_cfg_data;
                    pidt_pkg::REG_GAIN_D:     r_gain_d     <= i_cfg_data;
                    pidt_pkg::REG_LIMIT_LOW:  r_limit_low  <= i_cfg_data;
                    pidt_pkg::REG_LIMIT_HIGH: r_limit_high <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_opa        <= n_opa;
        r_opb        <= n_opb;
        r_num        <= n_num;
        r_den        <= n_den;
        r_err        <= n_err;
        r_ticks      <= n_ticks;
        r_now        <= n_now;
        r_ilo        <= n_ilo;
        r_dmag       <= n_dmag;
        r_dneg       <= n_dneg;
        r_sum        <= n_sum;
        r_res_drive  <= n_res_drive;
        r_res_status <= n_res_status;
        r_drive      <= n_drive;
        r_status     <= n_status;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_status    = r_status;

    // the two serial units never finish together
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({mul_done, div_done}))
        else $error("multiplier and divider finished in the same cycle");

    // a zero interval leaves the controller state untouched
    a_zero_interval_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_restart && r_prev_time != 32'd0 && i_time_ms == r_prev_time)
        |=> ($stable(r_acc) && $stable(r_prev_time) && $stable(r_prev_err)))
        else $error("zero interval changed controller state");

    // a first sample stores its time at once
    a_first_stores_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_restart || r_prev_time == 32'd0))
        |=> (r_prev_time == $past(i_time_ms)))
        else $error("first sample did not store its time");

    // no status code beyond the three defined ones leaves the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == pidt_pkg::ST_COMPUTED || o_status == pidt_pkg::ST_FIRST
                         || o_status == pidt_pkg::ST_ZERO))
        else $error("undefined status code on output");

endmodule
`default_nettype wire
